[rtl/kvt_pkg.sv]
// Shared types and constants of the key/value table engine.
package kvt_pkg;

  localparam int unsigned KEY_W       = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_INSERT      = 3'd0,
    CMD_FIND        = 3'd1,
    CMD_INDEX_KEY   = 3'd2,
    CMD_INDEX_VALUE = 3'd3,
    CMD_SUBSTITUTE  = 3'd4,
    CMD_DELETE      = 3'd5
  } kvt_cmd_e;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_FIND,
    OP_INDEX_KEY,
    OP_INDEX_VALUE,
    OP_SUBSTITUTE,
    OP_DELETE,
    OP_NOP,
    OP_REJECT
  } kvt_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_KEY_ZERO  = 2'd3
  } kvt_status_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } kvt_entry_t;

  typedef struct packed {
    kvt_op_e            op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } kvt_job_t;

  typedef struct packed {
    kvt_status_e        status;
    logic [KEY_W-1:0]   found_key;
    logic [VALUE_W-1:0] found_value;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
  } kvt_rsp_t;

  localparam int unsigned ENTRY_W = $bits(kvt_entry_t);

endpackage

[rtl/kvt_if.sv]
// Command and result channel interfaces of the key/value table engine.
interface kvt_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          command;
  logic [kvt_pkg::KEY_W-1:0]           entry_key;
  logic signed [kvt_pkg::VALUE_W-1:0]  entry_value;

  modport source (output valid, command, entry_key, entry_value, input ready);
  modport sink (input valid, command, entry_key, entry_value, output ready);
endinterface

interface kvt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [kvt_pkg::KEY_W-1:0]           found_key;
  logic signed [kvt_pkg::VALUE_W-1:0]  found_value;
  logic [kvt_pkg::POS_W-1:0]           position;
  logic [kvt_pkg::COUNT_W-1:0]         entry_count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, status, found_key, found_value, position, entry_count,
                  is_empty, is_full, input ready);
  modport sink (input valid, status, found_key, found_value, position, entry_count,
                is_empty, is_full, output ready);
endinterface

[rtl/kvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kvt_front.sv]
// Front end: takes command items and classifies them into jobs for the queue.
module kvt_front (
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [2:0]                command_i,
  input  logic [kvt_pkg::KEY_W-1:0] key_i,
  input  logic [kvt_pkg::VALUE_W-1:0] value_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output kvt_pkg::kvt_job_t         job_o
);

  kvt_pkg::kvt_op_e op;

  always_comb begin
    unique case (kvt_pkg::kvt_cmd_e'(command_i))
      kvt_pkg::CMD_INSERT:      op = kvt_pkg::OP_INSERT;
      kvt_pkg::CMD_FIND:        op = kvt_pkg::OP_FIND;
      kvt_pkg::CMD_INDEX_KEY:   op = kvt_pkg::OP_INDEX_KEY;
      kvt_pkg::CMD_INDEX_VALUE: op = kvt_pkg::OP_INDEX_VALUE;
      kvt_pkg::CMD_SUBSTITUTE:  op = kvt_pkg::OP_SUBSTITUTE;
      kvt_pkg::CMD_DELETE:      op = kvt_pkg::OP_DELETE;
      default:                  op = kvt_pkg::OP_NOP;
    endcase
    // Every command that carries a key refuses key zero.
    if (key_i == '0 && op != kvt_pkg::OP_INDEX_VALUE && op != kvt_pkg::OP_NOP) begin
      op = kvt_pkg::OP_REJECT;
    end
  end

  assign job_o.op     = op;
  assign job_o.key    = key_i;
  assign job_o.value  = value_i;
  assign push_valid_o = valid_i;
  assign ready_o      = push_ready_i;

endmodule

[rtl/kvt_queue.sv]
// Short job queue that decouples the front end from the back end.
module kvt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  kvt_pkg::kvt_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output kvt_pkg::kvt_job_t pop_data_o
);

  localparam int unsigned Depth = kvt_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  kvt_pkg::kvt_job_t slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = fill_q != CntW'(Depth);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/kvt_back.sv]
// Back end: executes table jobs, scanning the entry RAM where a job needs it, and registers each result.
module kvt_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  kvt_pkg::kvt_job_t job_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output kvt_pkg::kvt_rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PosW  = kvt_pkg::POS_W;
  localparam int unsigned OutCW = kvt_pkg::COUNT_W;
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  kvt_pkg::kvt_job_t      job_q, job_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        rd_idx_q, rd_idx_d;
  logic [CntW-1:0]        wr_idx_q, wr_idx_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic                   pend_q, pend_d;
  logic [AddrW-1:0]       pidx_q, pidx_d;
  logic                   rsp_valid_q, rsp_valid_d;
  kvt_pkg::kvt_rsp_t      rsp_q, rsp_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  kvt_pkg::kvt_entry_t    ram_wdata, ram_rdata;

  logic                   finish;
  kvt_pkg::kvt_status_e   fin_status;
  logic [kvt_pkg::KEY_W-1:0]   fin_key;
  logic [kvt_pkg::VALUE_W-1:0] fin_value;
  logic [CntW-1:0]        fin_pos, fin_count;
  logic                   hit_key, hit_value;

  kvt_ram #(
    .WIDTH (kvt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hit_key   = ram_rdata.key == job_q.key;
  assign hit_value = ram_rdata.value == job_q.value;
  assign ram_raddr = rd_idx_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    job_ready_o = 1'b0;
    finish      = 1'b0;
    fin_status  = kvt_pkg::ST_OK;
    fin_key     = '0;
    fin_value   = '0;
    fin_pos     = '0;
    fin_count   = count_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        job_ready_o = !rsp_valid_q;
        if (job_valid_i && !rsp_valid_q) begin
          unique case (job_i.op)
            kvt_pkg::OP_INSERT: begin
              finish = 1'b1;
              if (count_q == Depth) begin
                fin_status = kvt_pkg::ST_FULL;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[AddrW-1:0];
                ram_wdata.key   = job_i.key;
                ram_wdata.value = job_i.value;
                fin_count       = count_q + 1'b1;
              end
            end
            kvt_pkg::OP_NOP: begin
              finish = 1'b1;
            end
            kvt_pkg::OP_REJECT: begin
              finish     = 1'b1;
              fin_status = kvt_pkg::ST_KEY_ZERO;
            end
            default: begin
              state_d  = S_SCAN;
              job_d    = job_i;
              rd_idx_d = '0;
              wr_idx_d = '0;
              pos_d    = '0;
              pend_d   = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_idx_q != count_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
          pidx_d   = rd_idx_q[AddrW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          unique case (job_q.op)
            kvt_pkg::OP_FIND: begin
              if (hit_key) begin
                finish    = 1'b1;
                fin_key   = ram_rdata.key;
                fin_value = ram_rdata.value;
              end
            end
            kvt_pkg::OP_SUBSTITUTE: begin
              if (hit_key) begin
                finish          = 1'b1;
                ram_we          = 1'b1;
                ram_waddr       = pidx_q;
                ram_wdata.key   = job_q.key;
                ram_wdata.value = job_q.value;
              end
            end
            kvt_pkg::OP_INDEX_KEY: begin
              if (hit_key) begin
                pos_d = CntW'(pidx_q) + 1'b1;
              end
            end
            kvt_pkg::OP_INDEX_VALUE: begin
              if (hit_value) begin
                pos_d = CntW'(pidx_q) + 1'b1;
              end
            end
            kvt_pkg::OP_DELETE: begin
              if (!hit_key) begin
                ram_we    = 1'b1;
                ram_waddr = wr_idx_q[AddrW-1:0];
                ram_wdata = ram_rdata;
                wr_idx_d  = wr_idx_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (rd_idx_q == count_q) begin
          finish = 1'b1;
          unique case (job_q.op)
            kvt_pkg::OP_FIND: begin
              fin_status = kvt_pkg::ST_NOT_FOUND;
            end
            kvt_pkg::OP_INDEX_KEY, kvt_pkg::OP_INDEX_VALUE: begin
              fin_pos    = pos_q;
              fin_status = (pos_q != '0) ? kvt_pkg::ST_OK : kvt_pkg::ST_NOT_FOUND;
            end
            kvt_pkg::OP_SUBSTITUTE: begin
              if (count_q == Depth) begin
                fin_status = kvt_pkg::ST_FULL;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[AddrW-1:0];
                ram_wdata.key   = job_q.key;
                ram_wdata.value = job_q.value;
                fin_count       = count_q + 1'b1;
              end
            end
            kvt_pkg::OP_DELETE: begin
              fin_count  = wr_idx_q;
              fin_status = (wr_idx_q == count_q) ? kvt_pkg::ST_NOT_FOUND : kvt_pkg::ST_OK;
            end
            default: begin
            end
          endcase
        end
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      rsp_valid_d       = 1'b1;
      count_d           = fin_count;
      rsp_d.status      = fin_status;
      rsp_d.found_key   = fin_key;
      rsp_d.found_value = fin_value;
      rsp_d.position    = PosW'(fin_pos);
      rsp_d.entry_count = OutCW'(fin_count);
      rsp_d.is_empty    = fin_count == '0;
      rsp_d.is_full     = fin_count == Depth;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    pidx_q <= pidx_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("Entry count exceeds the table depth.");

  a_compact_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> wr_idx_q <= rd_idx_q && rd_idx_q <= count_q)
    else $error("Compaction pointer overtook the scan pointer.");

  a_scan_rsp_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !rsp_valid_q)
    else $error("A scan is running while a result is still pending.");

  a_finish_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> rsp_valid_q && state_q == S_IDLE)
    else $error("A finished job did not produce a result.");

endmodule

[rtl/key_value_table_engine_top.sv]
// Top level of the key/value table engine.
// The table holds up to TABLE_DEPTH entries of an 8-bit key and a 32-bit value in one RAM,
// packed from slot 0. Command items are classified on entry and wait in a two-item queue,
// so the command channel keeps accepting while the queue has room, also while the back end
// works and while a result waits to be taken. Insert, key-zero rejects and unused codes
// finish without a scan. Find, index by key, index by value, substitute and delete scan
// the stored entries through the single RAM read port, one entry per cycle; find and
// substitute stop at the first matching entry. Each result is held in an output register
// until taken. The table needs no clearing after reset.
module key_value_table_engine_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  kvt_cmd_if.sink    cmd_i,
  kvt_rsp_if.source  rsp_o
);

  logic              push_valid, push_ready;
  kvt_pkg::kvt_job_t push_job;
  logic              job_valid, job_ready;
  kvt_pkg::kvt_job_t job;
  logic              rsp_valid;
  kvt_pkg::kvt_rsp_t rsp;

  kvt_front u_front (
    .valid_i      (cmd_i.valid),
    .ready_o      (cmd_i.ready),
    .command_i    (cmd_i.command),
    .key_i        (cmd_i.entry_key),
    .value_i      (cmd_i.entry_value),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  kvt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job)
  );

  kvt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.status      = rsp.status;
  assign rsp_o.found_key   = rsp.found_key;
  assign rsp_o.found_value = rsp.found_value;
  assign rsp_o.position    = rsp.position;
  assign rsp_o.entry_count = rsp.entry_count;
  assign rsp_o.is_empty    = rsp.is_empty;
  assign rsp_o.is_full     = rsp.is_full;

endmodule
